FILE: hdl/stack_mnemonic_line_parser_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mnemonic line parser
// Concurrent checks on the rising edge of clk, held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef STACK_MNEMONIC_LINE_PARSER_UNIT_ASSERT_SVH
`define STACK_MNEMONIC_LINE_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define SMLP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smlp assertion failed");

// next-cycle implication
`define SMLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smlp assertion failed");

`else

`define SMLP_ASSERT_NOW(lbl, ante, cons)
`define SMLP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/smlp_pkg.sv
// ----------------------------------------------------------------------------
// Mnemonic line parser package
// Keyword table, result codes and widths shared by the parser and its channels.
// ----------------------------------------------------------------------------
package smlp_pkg;

  localparam int ARG_WIDTH     = 64;
  localparam int OUT_ARG_WIDTH = 64;
  localparam int MAG_EXT_WIDTH = ARG_WIDTH + 4;
  localparam int KEY_COUNT     = 12;
  localparam int COMMENT_KEY   = 11;
  localparam int KEY_MAX_LEN   = 5;
  localparam int POS_WIDTH     = 3;

  localparam logic [ARG_WIDTH-1:0]     ARG_LIMIT     = ARG_WIDTH'(1) << (ARG_WIDTH - 1);
  localparam logic [MAG_EXT_WIDTH-1:0] MAG_LIMIT_EXT = MAG_EXT_WIDTH'(1) << (ARG_WIDTH - 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_POP   = 4'd1,
    OP_DUB   = 4'd2,
    OP_SWAP  = 4'd3,
    OP_JUMP  = 4'd4,
    OP_ADD   = 4'd5,
    OP_SUB   = 4'd6,
    OP_MUL   = 4'd7,
    OP_DIV   = 4'd8,
    OP_EMIT  = 4'd9,
    OP_TRACE = 4'd10
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_IGNORED   = 2'd0,
    KIND_STATEMENT = 2'd1,
    KIND_ERROR     = 2'd2
  } line_kind_t;

  // operand scanner states
  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } num_phase_t;

  // keyword prefixes in match priority order, the comment marker last
  localparam logic [7:0] KEY_TEXT [KEY_COUNT][KEY_MAX_LEN] = '{
    '{8'h70, 8'h75, 8'h73, 8'h68, 8'h20},  // "push "
    '{8'h70, 8'h6F, 8'h70, 8'h00, 8'h00},  // "pop"
    '{8'h64, 8'h75, 8'h62, 8'h00, 8'h00},  // "dub"
    '{8'h73, 8'h77, 8'h61, 8'h70, 8'h00},  // "swap"
    '{8'h6A, 8'h75, 8'h6D, 8'h70, 8'h20},  // "jump "
    '{8'h61, 8'h64, 8'h64, 8'h00, 8'h00},  // "add"
    '{8'h73, 8'h75, 8'h62, 8'h00, 8'h00},  // "sub"
    '{8'h6D, 8'h75, 8'h6C, 8'h00, 8'h00},  // "mul"
    '{8'h64, 8'h69, 8'h76, 8'h00, 8'h00},  // "div"
    '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74},  // "print"
    '{8'h64, 8'h65, 8'h62, 8'h75, 8'h67},  // "debug"
    '{8'h23, 8'h20, 8'h00, 8'h00, 8'h00}   // "# "
  };

  localparam logic [POS_WIDTH-1:0] KEY_LEN [KEY_COUNT] = '{
    3'd5, 3'd3, 3'd3, 3'd4, 3'd5, 3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd5, 3'd2
  };

  // tab, newline, vertical tab, form feed, carriage return and space
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: hdl/smlp_in_if.sv
// ----------------------------------------------------------------------------
// Line byte channel
// Valid/ready channel carrying one byte of a text line per transaction.
// ----------------------------------------------------------------------------
interface smlp_in_if;

  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);

endinterface

FILE: hdl/smlp_out_if.sv
// ----------------------------------------------------------------------------
// Parsed line channel
// Valid/ready channel carrying the decoded result of one line per transaction.
// ----------------------------------------------------------------------------
interface smlp_out_if import smlp_pkg::*; ();

  logic                            valid;
  logic                            ready;
  logic [1:0]                      line_kind;
  logic [3:0]                      opcode;
  logic signed [OUT_ARG_WIDTH-1:0] argument;

  modport source (output valid, output line_kind, output opcode, output argument,
                  input ready);
  modport sink   (input valid, input line_kind, input opcode, input argument,
                  output ready);

endinterface

FILE: hdl/stack_mnemonic_line_parser_unit.sv
// ----------------------------------------------------------------------------
// Stack mnemonic line parser
// Decodes a zero-terminated text line into an opcode and a signed operand.
// ----------------------------------------------------------------------------
// The block takes one byte of a line per transaction on bytes, one per clock
// unless a terminator stalls, and a zero byte closes the line. Each line gives
// exactly one transaction on results: line_kind 0 for an empty, blank or "# "
// comment line, 1 for a statement with its opcode, 2 for a line that starts
// with no known keyword. push and jump carry a decimal operand read from the
// sixth byte on (leading whitespace, optional sign, digits), saturated at the
// signed 64-bit limits; every other case reports argument 0. Unstalled, the
// throughput is one byte per cycle, set by the combinational keyword match and
// multiply-by-ten accumulate behind the byte register. A terminator waits in
// the byte register until the result register is free, then loads it; bytes
// keep flowing while a result waits, until a second terminator meets it untaken.
`include "stack_mnemonic_line_parser_unit_assert.svh"

module stack_mnemonic_line_parser_unit import smlp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  smlp_in_if.sink       bytes,
  smlp_out_if.source    results
);

  // input register
  logic       byte_vld;
  logic [7:0] byte_q;

  // per-line parse state
  logic [POS_WIDTH-1:0] char_position,    char_position_next;
  logic [KEY_COUNT-1:0] candidate_mask,   candidate_mask_next;
  logic                 only_space_seen,  only_space_seen_next;
  num_phase_t           number_phase,     number_phase_next;
  logic                 number_negative,  number_negative_next;
  logic [ARG_WIDTH-1:0] number_magnitude, number_magnitude_next;

  // result register
  logic                            out_vld;
  line_kind_t                      kind_q;
  opcode_t                         opcode_q;
  logic signed [OUT_ARG_WIDTH-1:0] argument_q;

  logic                     is_term;
  logic                     advance;
  logic [MAG_EXT_WIDTH-1:0] mag_scaled;
  logic [ARG_WIDTH-1:0]     arg_value;
  logic                     comment_line;
  logic                     key_hit;
  opcode_t                  key_op;
  line_kind_t               kind_next;
  opcode_t                  opcode_next;
  logic signed [OUT_ARG_WIDTH-1:0] argument_next;

  assign is_term = (byte_q == CH_NUL);
  // a terminator moves on only when the result register is free
  assign advance     = byte_vld && (!is_term || !out_vld || results.ready);
  assign bytes.ready = !byte_vld || advance;

  // byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (bytes.ready) begin
      byte_vld <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      byte_q <= bytes.ch;
    end
  end

  // operand accumulate: value * 10 + digit, saturating at the magnitude limit
  assign mag_scaled = ({4'b0, number_magnitude} << 3) + ({4'b0, number_magnitude} << 1)
                      + MAG_EXT_WIDTH'(byte_q[3:0]);

  // parse state next value
  always_comb begin
    char_position_next    = char_position;
    candidate_mask_next   = candidate_mask;
    only_space_seen_next  = only_space_seen;
    number_phase_next     = number_phase;
    number_negative_next  = number_negative;
    number_magnitude_next = number_magnitude;
    if (advance) begin
      if (is_term) begin
        char_position_next    = '0;
        candidate_mask_next   = '1;
        only_space_seen_next  = 1'b1;
        number_phase_next     = PH_SKIP;
        number_negative_next  = 1'b0;
        number_magnitude_next = '0;
      end else begin
        if (!is_space(byte_q)) begin
          only_space_seen_next = 1'b0;
        end
        if (char_position < POS_WIDTH'(KEY_MAX_LEN)) begin
          // keyword prefix match, one column per byte
          for (int k = 0; k < KEY_COUNT; k++) begin
            if ((char_position < KEY_LEN[k]) &&
                (KEY_TEXT[k][char_position] != byte_q)) begin
              candidate_mask_next[k] = 1'b0;
            end
          end
          char_position_next = char_position + POS_WIDTH'(1);
        end else if ((number_phase == PH_SKIP) && is_space(byte_q)) begin
          number_phase_next = PH_SKIP;
        end else if ((number_phase == PH_SKIP) &&
                     ((byte_q == CH_PLUS) || (byte_q == CH_MINUS))) begin
          number_negative_next = (byte_q == CH_MINUS);
          number_phase_next    = PH_SIGN;
        end else if ((number_phase != PH_DONE) && is_digit(byte_q)) begin
          number_phase_next = PH_DIGITS;
          if (mag_scaled > MAG_LIMIT_EXT) begin
            number_magnitude_next = ARG_LIMIT;
          end else begin
            number_magnitude_next = mag_scaled[ARG_WIDTH-1:0];
          end
        end else begin
          number_phase_next = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position    <= '0;
      candidate_mask   <= '1;
      only_space_seen  <= 1'b1;
      number_phase     <= PH_SKIP;
      number_negative  <= 1'b0;
      number_magnitude <= '0;
    end else begin
      char_position    <= char_position_next;
      candidate_mask   <= candidate_mask_next;
      only_space_seen  <= only_space_seen_next;
      number_phase     <= number_phase_next;
      number_negative  <= number_negative_next;
      number_magnitude <= number_magnitude_next;
    end
  end

  // operand value with sign applied and positive overflow clamped
  always_comb begin
    if (number_negative) begin
      arg_value = ~number_magnitude + ARG_WIDTH'(1);
    end else if (number_magnitude >= ARG_LIMIT) begin
      arg_value = ARG_LIMIT - ARG_WIDTH'(1);
    end else begin
      arg_value = number_magnitude;
    end
  end

  // first surviving keyword that was seen in full
  always_comb begin
    key_hit = 1'b0;
    key_op  = OP_PUSH;
    for (int k = COMMENT_KEY - 1; k >= 0; k--) begin
      if (candidate_mask[k] && (char_position >= KEY_LEN[k])) begin
        key_hit = 1'b1;
        key_op  = opcode_t'(4'(k));
      end
    end
  end

  assign comment_line = candidate_mask[COMMENT_KEY] &&
                        (char_position >= KEY_LEN[COMMENT_KEY]);

  // line classification
  always_comb begin
    kind_next     = KIND_ERROR;
    opcode_next   = OP_PUSH;
    argument_next = '0;
    if (comment_line || only_space_seen) begin
      kind_next = KIND_IGNORED;
    end else if (key_hit) begin
      kind_next   = KIND_STATEMENT;
      opcode_next = key_op;
      if ((key_op == OP_PUSH) || (key_op == OP_JUMP)) begin
        argument_next = OUT_ARG_WIDTH'($signed(arg_value));
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && is_term) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_term) begin
      kind_q     <= kind_next;
      opcode_q   <= opcode_next;
      argument_q <= argument_next;
    end
  end

  assign results.valid     = out_vld;
  assign results.line_kind = kind_q;
  assign results.opcode    = opcode_q;
  assign results.argument  = argument_q;

  // checks
  `SMLP_ASSERT_NOW(a_nonstmt_zero, out_vld && (kind_q != KIND_STATEMENT), (opcode_q == OP_PUSH) && (argument_q == '0))
  `SMLP_ASSERT_NOW(a_arg_only_push_jump, out_vld && (argument_q != '0), (opcode_q == OP_PUSH) || (opcode_q == OP_JUMP))
  `SMLP_ASSERT_NEXT(a_term_held, byte_vld && is_term && !advance, byte_vld && is_term)
  `SMLP_ASSERT_NEXT(a_line_cleared, advance && is_term, (char_position == '0) && (candidate_mask == '1) && only_space_seen)
  `SMLP_ASSERT_NOW(a_position_bound, 1'b1, char_position <= POS_WIDTH'(KEY_MAX_LEN))

endmodule

FILE: dv/stack_mnemonic_line_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mnemonic line parser testbench
// Streams zero-terminated text lines into the parser under random idling on
// both channels. A scoreboard decodes each accepted byte on its own and
// compares every parsed line against the oldest line still outstanding.
// ----------------------------------------------------------------------------
module stack_mnemonic_line_parser_unit_tb;
  import smlp_pkg::*;

  // decoded line as the scoreboard predicts it
  typedef struct {
    line_kind_t         kind;
    opcode_t            op;
    logic signed [63:0] arg;
  } parsed_line_t;

  // operand scanner phases
  typedef enum logic [1:0] {
    SCAN_SKIP   = 2'd0,
    SCAN_SIGN   = 2'd1,
    SCAN_DIGITS = 2'd2,
    SCAN_DONE   = 2'd3
  } scan_phase_t;

  localparam int COMMENT_SLOT = 11;
  localparam int BODY_COL     = 5;
  localparam int RANDOM_BYTES = 1600;

  // keyword prefixes in match priority order, comment marker last
  localparam string KEYWORDS [12] = '{
    "push ", "pop", "dub", "swap", "jump ", "add", "sub", "mul", "div",
    "print", "debug", "# "
  };

  // --------------------------------------------------------------------------
  // scoreboard: decodes accepted bytes and checks parsed lines
  // --------------------------------------------------------------------------
  class line_scoreboard;
    logic [2:0]   col;
    logic [11:0]  alive;
    bit           blank;
    scan_phase_t  phase;
    bit           neg;
    logic [63:0]  mag;
    parsed_line_t lines_due[$];
    int           fail_count;
    int           bytes_seen;
    int           lines_done;
    int           n_stmt;
    int           n_ignored;
    int           n_error;

    function new();
      fail_count = 0;
      bytes_seen = 0;
      lines_done = 0;
      n_stmt     = 0;
      n_ignored  = 0;
      n_error    = 0;
      clear_line();
    endfunction

    function void clear_line();
      col   = '0;
      alive = '1;
      blank = 1'b1;
      phase = SCAN_SKIP;
      neg   = 1'b0;
      mag   = '0;
    endfunction

    function bit is_white(logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // atoll-style operand scan, one byte at a time
    function void scan_operand(logic [7:0] c);
      logic [63:0] lim;
      logic [63:0] d;
      lim = 64'd1 << (ARG_WIDTH - 1);
      if (phase == SCAN_SKIP && is_white(c)) begin
        return;
      end
      if (phase == SCAN_SKIP && (c == "+" || c == "-")) begin
        neg   = (c == "-");
        phase = SCAN_SIGN;
        return;
      end
      if (phase != SCAN_DONE && c >= "0" && c <= "9") begin
        d     = 64'(c - 8'h30);
        phase = SCAN_DIGITS;
        if (mag > (lim - d) / 64'd10) mag = lim;
        else mag = mag * 64'd10 + d;
      end else begin
        phase = SCAN_DONE;
      end
    endfunction

    // saturated operand, sign-extended from the argument width
    function logic signed [63:0] operand_value();
      logic [63:0] lim;
      logic [63:0] msk;
      logic [63:0] v;
      lim = 64'd1 << (ARG_WIDTH - 1);
      msk = (ARG_WIDTH >= 64) ? '1 : ((64'd1 << ARG_WIDTH) - 64'd1);
      if (neg) v = (64'd0 - mag) & msk;
      else v = (mag >= lim) ? lim - 64'd1 : mag;
      if ((v & lim) != 0) v = v | ~msk;
      return v;
    endfunction

    // closes the line on the terminator and queues its decode
    function void close_line();
      parsed_line_t pl;
      bit found;
      pl.kind = KIND_ERROR;
      pl.op   = OP_PUSH;
      pl.arg  = '0;
      found   = 1'b0;
      if ((alive[COMMENT_SLOT] && col >= KEYWORDS[COMMENT_SLOT].len()) || blank) begin
        pl.kind = KIND_IGNORED;
      end else begin
        for (int k = 0; k < COMMENT_SLOT; k++) begin
          if (!found && alive[k] && col >= KEYWORDS[k].len()) begin
            found   = 1'b1;
            pl.kind = KIND_STATEMENT;
            pl.op   = opcode_t'(k);
            if (pl.op == OP_PUSH || pl.op == OP_JUMP) pl.arg = operand_value();
          end
        end
      end
      case (pl.kind)
        KIND_IGNORED:   n_ignored++;
        KIND_STATEMENT: n_stmt++;
        default:        n_error++;
      endcase
      lines_due.push_back(pl);
      clear_line();
    endfunction

    function void note_byte(logic [7:0] c);
      bytes_seen++;
      if (c == 8'd0) begin
        close_line();
        return;
      end
      if (!is_white(c)) blank = 1'b0;
      if (col < BODY_COL) begin
        for (int k = 0; k < 12; k++) begin
          if (col < KEYWORDS[k].len() && KEYWORDS[k][col] != c) alive[k] = 1'b0;
        end
        col++;
      end else begin
        scan_operand(c);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [3:0] op, logic signed [63:0] arg);
      parsed_line_t pl;
      if (lines_due.size() == 0) begin
        $error("parsed line with no line outstanding: kind %0d opcode %0d", kind, op);
        fail_count++;
        return;
      end
      pl = lines_due.pop_front();
      lines_done++;
      if (kind !== pl.kind) begin
        $error("line_kind mismatch: expected %0d, actual %0d", pl.kind, kind);
        fail_count++;
      end
      if (op !== pl.op) begin
        $error("opcode mismatch: expected %0d, actual %0d", pl.op, op);
        fail_count++;
      end
      if (arg !== pl.arg) begin
        $error("argument mismatch: expected %0d, actual %0d", pl.arg, arg);
        fail_count++;
      end
    endfunction

    function int pending();
      return lines_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   tx_steady;
  bit   rx_steady;
  int   rx_hold;
  int   random_sent;
  int   pauses;

  smlp_in_if  in_ch ();
  smlp_out_if out_ch ();

  line_scoreboard sb = new();

  stack_mnemonic_line_parser_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .bytes   (in_ch),
    .results (out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // idle length: mostly none or short, a few long
  function automatic int idle_len(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_steady || $urandom_range(0, 1)) begin
      out_ch.ready <= 1'b1;
      rx_hold      <= $urandom_range(0, 6);
    end else begin
      out_ch.ready <= 1'b0;
      rx_hold      <= idle_len(1'b0);
    end
  end

  // byte transaction monitor
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) sb.note_byte(in_ch.ch);
  end

  // parsed line transaction monitor
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.line_kind, out_ch.opcode, out_ch.argument);
    end
  end

  // one byte transaction, valid held high across back-to-back bytes
  task automatic send_byte(input logic [7:0] c);
    int gap;
    gap = idle_len(tx_steady);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ch    <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic send_line(input logic [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i]);
    send_byte(8'd0);
  endtask

  task automatic send_text(input string s);
    logic [7:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_line(txt);
  endtask

  // sender holds off until every outstanding line has been parsed
  task automatic wait_all_parsed();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
    pauses++;
  endtask

  function automatic logic [7:0] white_byte();
    case ($urandom_range(0, 5))
      0:       return 8'd9;
      1:       return 8'd10;
      2:       return 8'd11;
      3:       return 8'd12;
      4:       return 8'd13;
      default: return 8'd32;
    endcase
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  // builds one random line, mostly well-formed
  task automatic build_line(output logic [7:0] txt[$]);
    int r;
    int k;
    int n;
    int at;
    string kw;
    txt.delete();
    r = $urandom_range(0, 99);
    if (r < 58) begin
      // statement, operand for push and jump
      k  = $urandom_range(0, 10);
      kw = KEYWORDS[k];
      for (int i = 0; i < kw.len(); i++) txt.push_back(kw[i]);
      if (k == 0 || k == 4) begin
        n = $urandom_range(0, 3);
        repeat (n) txt.push_back(white_byte());
        case ($urandom_range(0, 2))
          1:       txt.push_back("+");
          2:       txt.push_back("-");
          default: ;
        endcase
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(17, 22);
        repeat (n) txt.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) txt.push_back(any_byte());
      end
    end else if (r < 68) begin
      // comment with random body
      txt.push_back("#");
      txt.push_back(" ");
      n = $urandom_range(0, 6);
      repeat (n) txt.push_back(any_byte());
    end else if (r < 76) begin
      // blank line
      n = $urandom_range(0, 6);
      repeat (n) txt.push_back(white_byte());
    end else if (r < 90) begin
      // keyword truncated or with one byte changed
      k  = $urandom_range(0, 11);
      kw = KEYWORDS[k];
      for (int i = 0; i < kw.len(); i++) txt.push_back(kw[i]);
      if ($urandom_range(0, 1)) begin
        n = $urandom_range(1, kw.len());
        repeat (n) void'(txt.pop_back());
      end else begin
        at = $urandom_range(0, kw.len() - 1);
        txt[at] = any_byte();
        n = $urandom_range(0, 4);
        repeat (n) txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
    end else begin
      // noise
      n = $urandom_range(0, 12);
      repeat (n) txt.push_back(any_byte());
    end
  endtask

  // stimulus
  initial begin
    logic [7:0] txt[$];
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.ch     = 8'd0;
    out_ch.ready = 1'b0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    random_sent  = 0;
    pauses       = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed lines: blank, comment, extremes, every opcode
    send_text("");
    send_text("   ");
    txt = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32};
    send_line(txt);
    send_text("# hello");
    send_text("#x");
    send_text("push 123");
    send_text("push -9223372036854775808");
    send_text("push 9223372036854775807");
    send_text("push 9223372036854775808");
    send_text("push -99999999999999999999");
    send_text("push");
    txt = '{"p", "u", "s", "h", " ", 8'd9, " ", "+", "4", "2", "x", "9"};
    send_line(txt);
    send_text("jump 7");
    send_text("jump abc");
    send_text("jump -");
    send_text("pop");
    send_text("dub");
    send_text("swap");
    send_text("add");
    send_text("sub");
    send_text("mul");
    send_text("div");
    send_text("print");
    send_text("debug");
    send_text("popcorn");
    txt = '{8'hFF, 8'h80, 8'h7F, 8'hA0};
    send_line(txt);
    send_text("push 1 2");
    wait_all_parsed();

    // random lines, idling style changes every few dozen lines
    for (int ln = 0; random_sent < RANDOM_BYTES; ln++) begin
      if (ln % 40 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      build_line(txt);
      send_line(txt);
      random_sent += txt.size() + 1;
      if ($urandom_range(0, 49) == 0) wait_all_parsed();
    end

    wait_all_parsed();
    repeat (16) @(posedge clk);
    $display("covered %0d bytes in %0d lines: %0d statements, %0d ignored, %0d errors",
             sb.bytes_seen, sb.lines_done, sb.n_stmt, sb.n_ignored, sb.n_error);
    $display("sender paused for a full drain %0d times", pauses);
    if (sb.fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
